/* hw/rtl/kca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kca_pkg: keypad click / autorepeat shared definitions
// Key table, code lookup, register indexes and field widths.
// ----------------------------------------------------------------------------
package kca_pkg;

  localparam int unsigned NUM_ENTRIES = 29;
  localparam int unsigned NUM_CODES   = 25;
  localparam int unsigned CODE_W      = 5;
  localparam int unsigned ENTRY_W     = 5;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned DELAY_W     = 16;
  localparam int unsigned CFG_IDX_W   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 8'd1;

  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST  = 16'd500;
  localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = 16'd175;

  typedef struct packed {
    logic              grp;
    logic [CODE_W-1:0] code;
    logic [WORD_W-1:0] mask;
  } key_entry_t;

  localparam key_entry_t KEY_TABLE [NUM_ENTRIES] = '{
    '{1'b0, 5'd1,  32'h0000_0020}, '{1'b0, 5'd2,  32'h0000_0020},
    '{1'b0, 5'd1,  32'h0000_0040}, '{1'b0, 5'd3,  32'h0000_0040},
    '{1'b0, 5'd1,  32'h0000_0060}, '{1'b0, 5'd4,  32'h0000_0060},
    '{1'b0, 5'd5,  32'h0000_0080}, '{1'b0, 5'd6,  32'h0000_0080},
    '{1'b0, 5'd5,  32'h0000_0100}, '{1'b0, 5'd7,  32'h0000_0100},
    '{1'b0, 5'd5,  32'h0000_0180}, '{1'b0, 5'd8,  32'h0000_0180},
    '{1'b0, 5'd9,  32'h0000_0400}, '{1'b0, 5'd10, 32'h0000_0800},
    '{1'b0, 5'd11, 32'h0000_1000}, '{1'b0, 5'd12, 32'h0000_2000},
    '{1'b0, 5'd13, 32'h0000_4000}, '{1'b0, 5'd14, 32'h0000_8000},
    '{1'b0, 5'd15, 32'h0001_0000}, '{1'b0, 5'd16, 32'h0002_0000},
    '{1'b0, 5'd17, 32'h0004_0000}, '{1'b0, 5'd18, 32'h0008_0000},
    '{1'b0, 5'd19, 32'h0040_0000}, '{1'b0, 5'd20, 32'h0080_0000},
    '{1'b1, 5'd21, 32'h0000_0300}, '{1'b1, 5'd22, 32'h0000_0200},
    '{1'b1, 5'd23, 32'h0000_0100}, '{1'b1, 5'd24, 32'h0000_0400},
    '{1'b1, 5'd25, 32'h0000_0800}
  };

  // first table entry of each code; codes without a key map to entry 0
  localparam logic [ENTRY_W-1:0] FIRST_ENTRY [2**CODE_W] = '{
    5'd0,  5'd0,  5'd1,  5'd3,  5'd5,  5'd6,  5'd7,  5'd9,
    5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18,
    5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26,
    5'd27, 5'd28, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0
  };

endpackage

/* hw/rtl/kca_scan_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kca_scan_if: keyboard scan channel
// One transfer carries two active-low key words and a millisecond stamp.
// ----------------------------------------------------------------------------
interface kca_scan_if;
  logic        valid;
  logic        ready;
  logic [31:0] scan_group0;
  logic [31:0] scan_group2;
  logic [31:0] now_ms;

  modport source (output valid, output scan_group0, output scan_group2,
                  output now_ms, input ready);
  modport sink   (input valid, input scan_group0, input scan_group2,
                  input now_ms, output ready);
endinterface

/* hw/rtl/kca_key_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kca_key_if: key event channel
// One transfer carries a key code and its repeat flag.
// ----------------------------------------------------------------------------
interface kca_key_if;
  logic       valid;
  logic       ready;
  logic [4:0] key_code;
  logic       is_repeat;

  modport source (output valid, output key_code, output is_repeat, input ready);
  modport sink   (input valid, input key_code, input is_repeat, output ready);
endinterface

/* hw/rtl/kca_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kca_cfg_if: configuration write channel
// One transfer writes data to the register selected by index.
// ----------------------------------------------------------------------------
interface kca_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/keypad_click_autorepeat.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_click_autorepeat: key click detection with typematic autorepeat
//
// scan_i takes one keyboard scan per transfer (two active-low key words and
// a millisecond stamp). key_o returns exactly one result per scan: the code
// of the first key that went down, the held key again once its delay has
// run out (is_repeat set), or code 0. cfg_i writes first_delay_ms (index 0)
// and repeat_delay_ms (index 1); other indexes are dropped. cfg_i is always
// ready.
// A scan transfer lands in an input register, then the table compare and the
// 32-bit elapsed-time compare load the result register once it is empty or
// being taken. Throughput is one scan per cycle while key_o does not stall,
// set by that single compute stage, which also updates the key state.
// Reset sets the delays to 500 and 175 ms, marks all keys released and
// empties both stages. When key_o stalls, one result waits in the output
// register and one scan in the input register; scan_i then drops ready.
// ----------------------------------------------------------------------------
module keypad_click_autorepeat (
  input  logic  clk_i,
  input  logic  rst_ni,
  kca_scan_if.sink   scan_i,
  kca_key_if.source  key_o,
  kca_cfg_if.sink    cfg_i
);
  import kca_pkg::*;

  logic [DELAY_W-1:0] first_delay_q, first_delay_d;
  logic [DELAY_W-1:0] repeat_delay_q, repeat_delay_d;

  logic              s1_valid_q, s1_valid_d;
  logic [WORD_W-1:0] s1_g0_q, s1_g0_d;
  logic [WORD_W-1:0] s1_g2_q, s1_g2_d;
  logic [WORD_W-1:0] s1_now_q, s1_now_d;

  logic [WORD_W-1:0] prev_g0_q, prev_g0_d;
  logic [WORD_W-1:0] prev_g2_q, prev_g2_d;
  logic [CODE_W-1:0] held_q, held_d;
  logic [WORD_W-1:0] last_time_q, last_time_d;
  logic              repeating_q, repeating_d;

  logic              out_valid_q, out_valid_d;
  logic [CODE_W-1:0] out_code_q, out_code_d;
  logic              out_rep_q, out_rep_d;

  logic scan_xfer, advance;

  logic [NUM_ENTRIES-1:0] fell, first_hot;
  logic [CODE_W-1:0]      click_code;
  logic [ENTRY_W-1:0]     held_idx;
  key_entry_t             held_entry;
  logic [WORD_W-1:0]      held_word;
  logic                   held_valid, held_down;
  logic [WORD_W-1:0]      elapsed;
  logic [DELAY_W-1:0]     limit;
  logic                   timeout;

  assign advance      = s1_valid_q && (!out_valid_q || key_o.ready);
  assign scan_i.ready = !s1_valid_q || advance;
  assign scan_xfer    = scan_i.valid && scan_i.ready;
  assign cfg_i.ready  = 1'b1;

  // falling edges of each table mask, then lowest entry wins
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      fell[i] = KEY_TABLE[i].grp ?
                ((prev_g2_q & KEY_TABLE[i].mask) != '0) &&
                ((s1_g2_q & KEY_TABLE[i].mask) == '0) :
                ((prev_g0_q & KEY_TABLE[i].mask) != '0) &&
                ((s1_g0_q & KEY_TABLE[i].mask) == '0);
    end
    first_hot  = fell & (~fell + NUM_ENTRIES'(1));
    click_code = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      click_code = click_code | ({CODE_W{first_hot[i]}} & KEY_TABLE[i].code);
    end
  end

  always_comb begin
    held_idx   = FIRST_ENTRY[held_q];
    held_entry = KEY_TABLE[held_idx];
    held_word  = held_entry.grp ? s1_g2_q : s1_g0_q;
    held_valid = (held_q != '0) && (held_q <= CODE_W'(NUM_CODES));
    held_down  = held_valid && ((held_word & held_entry.mask) == '0);
    elapsed    = s1_now_q - last_time_q;
    limit      = repeating_q ? repeat_delay_q : first_delay_q;
    timeout    = elapsed > {{(WORD_W-DELAY_W){1'b0}}, limit};
  end

  always_comb begin
    first_delay_d  = first_delay_q;
    repeat_delay_d = repeat_delay_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_FIRST_DELAY:  first_delay_d  = cfg_i.data;
        REG_REPEAT_DELAY: repeat_delay_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_g0_d    = s1_g0_q;
    s1_g2_d    = s1_g2_q;
    s1_now_d   = s1_now_q;
    if (scan_xfer) begin
      s1_valid_d = 1'b1;
      s1_g0_d    = scan_i.scan_group0;
      s1_g2_d    = scan_i.scan_group2;
      s1_now_d   = scan_i.now_ms;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    prev_g0_d   = prev_g0_q;
    prev_g2_d   = prev_g2_q;
    held_d      = held_q;
    last_time_d = last_time_q;
    repeating_d = repeating_q;
    out_valid_d = out_valid_q;
    out_code_d  = out_code_q;
    out_rep_d   = out_rep_q;
    if (advance) begin
      prev_g0_d   = s1_g0_q;
      prev_g2_d   = s1_g2_q;
      out_valid_d = 1'b1;
      out_code_d  = '0;
      out_rep_d   = 1'b0;
      if (click_code != '0) begin
        held_d      = click_code;
        repeating_d = 1'b0;
        last_time_d = s1_now_q;
        out_code_d  = click_code;
      end else if (held_down) begin
        if (timeout) begin
          repeating_d = 1'b1;
          last_time_d = s1_now_q;
          out_code_d  = held_q;
          out_rep_d   = 1'b1;
        end
      end else begin
        held_d = '0;
      end
    end else if (key_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_delay_q  <= FIRST_DELAY_RST;
      repeat_delay_q <= REPEAT_DELAY_RST;
      s1_valid_q     <= 1'b0;
      prev_g0_q      <= '1;
      prev_g2_q      <= '1;
      held_q         <= '0;
      last_time_q    <= '0;
      repeating_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      first_delay_q  <= first_delay_d;
      repeat_delay_q <= repeat_delay_d;
      s1_valid_q     <= s1_valid_d;
      prev_g0_q      <= prev_g0_d;
      prev_g2_q      <= prev_g2_d;
      held_q         <= held_d;
      last_time_q    <= last_time_d;
      repeating_q    <= repeating_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_g0_q    <= s1_g0_d;
    s1_g2_q    <= s1_g2_d;
    s1_now_q   <= s1_now_d;
    out_code_q <= out_code_d;
    out_rep_q  <= out_rep_d;
  end

  assign key_o.valid     = out_valid_q;
  assign key_o.key_code  = out_code_q;
  assign key_o.is_repeat = out_rep_q;

endmodule

/* tb/keypad_click_autorepeat_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_click_autorepeat_test: self-checking bench for keypad click/repeat
// Feeds keyboard scans through the scan channel and predicts each key event
// from a bench-side copy of the key table, held key, timer and delays.
// Every key event transfer is compared in order against the prediction.
// Directed scans cover the delay boundaries, time wrap, the held-key mask
// and the two-bit keys. Random phases then run press/hold/release sequences
// with noise under several delay settings, with random stalls on both sides
// and one long output hold-off.
// ----------------------------------------------------------------------------
module keypad_click_autorepeat_test;
  import kca_pkg::*;

  localparam int unsigned ENTRIES       = 29;
  localparam int unsigned G2_FIRST      = 24;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_SCANS   = 115;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned QUIET_LIMIT   = 4000;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP      = 8'hFF;

  typedef enum logic [4:0] {
    KC_NONE, KC_ZOOM_IN, KC_ZOOM_IN1, KC_ZOOM_IN2, KC_ZOOM_IN3,
    KC_ZOOM_OUT, KC_ZOOM_OUT1, KC_ZOOM_OUT2, KC_ZOOM_OUT3,
    KC_UP, KC_DN, KC_LT, KC_RT, KC_SET, KC_VIDEO,
    KC_ZOOM_ASSIST, KC_DISP, KC_MNU, KC_ERS, KC_FLSH, KC_PRN,
    KC_SHOOT_FULL, KC_SHOOT_FULL_ONLY, KC_SHOOT_HALF, KC_PWR,
    KC_PLAY
  } key_name_e;

  // entries from G2_FIRST on read the second key word
  localparam logic [31:0] KEY_MASK [ENTRIES] = '{
    32'h20, 32'h20, 32'h40, 32'h40, 32'h60, 32'h60, 32'h80, 32'h80,
    32'h100, 32'h100, 32'h180, 32'h180, 32'h400, 32'h800, 32'h1000,
    32'h2000, 32'h4000, 32'h8000, 32'h1_0000, 32'h2_0000, 32'h4_0000,
    32'h8_0000, 32'h40_0000, 32'h80_0000,
    32'h300, 32'h200, 32'h100, 32'h400, 32'h800
  };

  localparam key_name_e KEY_CODE [ENTRIES] = '{
    KC_ZOOM_IN, KC_ZOOM_IN1, KC_ZOOM_IN, KC_ZOOM_IN2, KC_ZOOM_IN,
    KC_ZOOM_IN3, KC_ZOOM_OUT, KC_ZOOM_OUT1, KC_ZOOM_OUT, KC_ZOOM_OUT2,
    KC_ZOOM_OUT, KC_ZOOM_OUT3, KC_UP, KC_DN, KC_LT, KC_RT,
    KC_SET, KC_VIDEO, KC_ZOOM_ASSIST, KC_DISP, KC_MNU, KC_ERS,
    KC_FLSH, KC_PRN, KC_SHOOT_FULL, KC_SHOOT_FULL_ONLY,
    KC_SHOOT_HALF, KC_PWR, KC_PLAY
  };

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              rep;
  } key_event_t;

  class key_event_book;
    int unsigned     mismatches;
    logic [15:0]     first_delay;
    logic [15:0]     repeat_delay;
    logic [31:0]     prev_g0;
    logic [31:0]     prev_g2;
    logic [31:0]     last_stamp;
    logic [4:0]      held;
    logic            repeating;
    key_event_t      expected_q[$];

    function new();
      mismatches   = 0;
      first_delay  = 16'd500;
      repeat_delay = 16'd175;
      prev_g0      = '1;
      prev_g2      = '1;
      last_stamp   = '0;
      held         = KC_NONE;
      repeating    = 1'b0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
      if (idx == REG_FIRST_DELAY) first_delay = val;
      else if (idx == REG_REPEAT_DELAY) repeat_delay = val;
    endfunction

    function void note_scan(input logic [31:0] g0, input logic [31:0] g2,
                            input logic [31:0] stamp);
      key_event_t  ev;
      logic [4:0]  hit;
      logic [31:0] was;
      logic [31:0] cur;
      logic [31:0] elapsed;
      logic        down;
      logic        seen;
      hit  = KC_NONE;
      down = 1'b0;
      seen = 1'b0;
      ev   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        was = (i >= G2_FIRST) ? prev_g2 : prev_g0;
        cur = (i >= G2_FIRST) ? g2 : g0;
        if (hit == KC_NONE && (was & KEY_MASK[i]) != 0 && (cur & KEY_MASK[i]) == 0)
          hit = KEY_CODE[i];
      end
      if (hit != KC_NONE) begin
        held       = hit;
        repeating  = 1'b0;
        last_stamp = stamp;
        ev.code    = hit;
      end else begin
        // held key is tested against its first table entry only
        for (int i = 0; i < ENTRIES; i++) begin
          if (!seen && KEY_CODE[i] == held) begin
            seen = 1'b1;
            down = ((((i >= G2_FIRST) ? g2 : g0) & KEY_MASK[i]) == 0);
          end
        end
        if (down) begin
          elapsed = stamp - last_stamp;
          if (elapsed > {16'd0, (repeating ? repeat_delay : first_delay)}) begin
            repeating  = 1'b1;
            last_stamp = stamp;
            ev.code    = held;
            ev.rep     = 1'b1;
          end
        end else begin
          held = KC_NONE;
        end
      end
      prev_g0 = g0;
      prev_g2 = g2;
      expected_q.push_back(ev);
    endfunction

    function void check_key(input logic [4:0] code, input logic rep);
      key_event_t ev;
      if (expected_q.size() == 0) begin
        $error("key event with none pending: key_code %0d is_repeat %0d", code, rep);
        mismatches++;
        return;
      end
      ev = expected_q.pop_front();
      if (code !== ev.code) begin
        $error("key_code mismatch: expected %0d, actual %0d", ev.code, code);
        mismatches++;
      end
      if (rep !== ev.rep) begin
        $error("is_repeat mismatch: expected %0d, actual %0d", ev.rep, rep);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  kca_scan_if scan_if ();
  kca_key_if  key_if ();
  kca_cfg_if  cfg_if ();

  keypad_click_autorepeat dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .scan_i (scan_if),
    .key_o  (key_if),
    .cfg_i  (cfg_if)
  );

  key_event_book book = new();

  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned quiet_cycles = 0;
  logic [31:0] word0 = '1;
  logic [31:0] word2 = '1;
  logic [31:0] stamp_ms = '0;
  logic [15:0] cur_first = 16'd500;
  logic [15:0] cur_repeat = 16'd175;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic send_scan(input logic [31:0] g0, input logic [31:0] g2,
                           input logic [31:0] stamp);
    while (idle_en && $urandom_range(99) < 16) begin
      scan_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    scan_if.valid       <= 1'b1;
    scan_if.scan_group0 <= g0;
    scan_if.scan_group2 <= g2;
    scan_if.now_ms      <= stamp;
    do @(posedge clk_i); while (!scan_if.ready);
    book.note_scan(g0, g2, stamp);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val,
                           input bit last);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    book.write_reg(idx, val);
    if (last) cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    scan_if.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // press / hold / release sequences with some noise, time steps near delays
  task automatic random_scan();
    int unsigned pick;
    int unsigned e;
    logic [31:0] lim;
    logic [31:0] dt;
    pick = $urandom_range(99);
    e    = $urandom_range(ENTRIES - 1);
    if (pick < 25) begin
      if (e >= G2_FIRST) word2 &= ~KEY_MASK[e];
      else word0 &= ~KEY_MASK[e];
    end else if (pick < 40) begin
      if (e >= G2_FIRST) word2 |= KEY_MASK[e];
      else word0 |= KEY_MASK[e];
    end else if (pick < 46) begin
      word0 = '1;
      word2 = '1;
    end else if (pick < 53) begin
      word0 = $urandom;
      word2 = $urandom;
    end
    lim  = $urandom_range(1) ? {16'd0, cur_first} : {16'd0, cur_repeat};
    pick = $urandom_range(99);
    if (pick < 30) dt = $urandom_range(3);
    else if (pick < 60) dt = lim + $urandom_range(2) - 1;
    else if (pick < 90) dt = $urandom_range(2 * lim + 2);
    else if (pick < 97) dt = $urandom;
    else dt = 32'hFFFF_FFFF - $urandom_range(3);
    stamp_ms += dt;
    send_scan(word0, word2, stamp_ms);
  endtask

  initial begin : key_sink
    int unsigned hold_left;
    hold_left = 0;
    key_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && key_if.valid && key_if.ready)
        book.check_key(key_if.key_code, key_if.is_repeat);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        key_if.ready <= 1'b0;
      end else begin
        key_if.ready <= !(idle_en && $urandom_range(99) < 16);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((scan_if.valid && scan_if.ready) || (key_if.valid && key_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("keypad_click_autorepeat_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_ni              <= 1'b0;
    scan_if.valid       <= 1'b0;
    scan_if.scan_group0 <= '1;
    scan_if.scan_group2 <= '1;
    scan_if.now_ms      <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= '0;
    cfg_if.data         <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset delays 500 / 175
    send_scan('1, '1, 32'd0);
    send_scan('0, '0, 32'd1);                  // all keys at once: first entry wins
    send_scan('0, '0, 32'd501);                // exactly the first delay: no repeat
    send_scan('0, '0, 32'd502);
    send_scan('0, '0, 32'd677);                // exactly the repeat delay
    send_scan('0, '0, 32'd678);
    send_scan('1, '1, 32'd700);
    send_scan(~32'h40, '1, 32'd710);           // zoom in via its second bit
    send_scan(~32'h40, '1, 32'd5000);          // held test sees 0x20 only: released
    send_scan('1, ~32'h400, 32'hFFFF_FF00);
    send_scan('1, ~32'h400, 32'h0000_0100);    // elapsed wraps past zero
    send_scan('1, ~32'h300, 32'h0000_0200);    // two-bit shutter key
    send_scan('1, ~32'h200, 32'h0000_0300);    // one bit lifted: key released
    send_scan(~32'h80_0000, '1, 32'h0000_0400);
    send_scan('1, '1, 32'h0000_0500);

    settle();
    write_reg(REG_UNMAPPED, 16'h1234, 1'b0);
    write_reg(REG_TOP, 16'hFFFF, 1'b0);
    write_reg(REG_FIRST_DELAY, 16'd0, 1'b0);
    write_reg(REG_REPEAT_DELAY, 16'd0, 1'b1);
    send_scan(~32'h4000, '1, 32'd100);
    send_scan(~32'h4000, '1, 32'd100);
    send_scan(~32'h4000, '1, 32'd101);
    send_scan(~32'h4000, '1, 32'd101);
    send_scan(~32'h4000, '1, 32'd102);

    settle();
    write_reg(REG_FIRST_DELAY, 16'hFFFF, 1'b0);
    write_reg(REG_REPEAT_DELAY, 16'hFFFF, 1'b1);
    send_scan(~32'h800, '1, 32'd0);
    send_scan(~32'h800, '1, 32'd65535);
    send_scan(~32'h800, '1, 32'd65536);
    send_scan(~32'h800, '1, 32'd131071);
    send_scan(~32'h800, '1, 32'd131072);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin cur_first = 16'd500;   cur_repeat = 16'd175;   end
        1: begin cur_first = 16'd0;     cur_repeat = 16'd0;     end
        2: begin cur_first = 16'hFFFF;  cur_repeat = 16'hFFFF;  end
        3: begin cur_first = 16'd40;    cur_repeat = 16'd12;    end
        4: begin
          cur_first  = 16'($urandom_range(300));
          cur_repeat = 16'($urandom_range(100));
        end
        default: begin cur_first = 16'd1; cur_repeat = 16'hFFFE; end
      endcase
      if (ph == 4)
        write_reg(CFG_IDX_W'(REG_UNMAPPED + $urandom_range(200)), 16'($urandom), 1'b0);
      write_reg(REG_FIRST_DELAY, cur_first, 1'b0);
      write_reg(REG_REPEAT_DELAY, cur_repeat, 1'b1);
      idle_en = (ph != 2);
      word0   = '1;
      word2   = '1;
      for (int n = 0; n < PHASE_SCANS; n++) begin
        if (ph == 3 && n == 20) hold_req = 1'b1;
        random_scan();
      end
    end

    settle();
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("keypad_click_autorepeat_test OK");
    end else begin
      $display("keypad_click_autorepeat_test NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/kca_pkg.sv
hw/rtl/kca_scan_if.sv
hw/rtl/kca_key_if.sv
hw/rtl/kca_cfg_if.sv
hw/rtl/keypad_click_autorepeat.sv
tb/keypad_click_autorepeat_test.sv
